// File: rtl/core/bfp_pkg.sv
// Package for the bencode frame parser: character codes, limits, parser
// phase type, result record and the decimal accumulate helper.
// No dependencies.
`default_nettype none

package bfp_pkg;

    // Default upper bound on a declared payload length (exclusive)
    localparam int BFP_MAX_DATA = 64;

    // Field widths of the result record
    localparam int NODE_W  = 16;
    localparam int INDEX_W = 6;
    localparam int LEN_W   = 6;

    // Saturation value of the decimal accumulators
    localparam logic [NODE_W-1:0] ACC_MAX = 16'hFFFF;

    // Character codes
    localparam logic [7:0] CH_LIST  = 8'h6C;  // 'l'
    localparam logic [7:0] CH_INT   = 8'h69;  // 'i'
    localparam logic [7:0] CH_END   = 8'h65;  // 'e'
    localparam logic [7:0] CH_COLON = 8'h3A;  // ':'
    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CH_NINE  = 8'h39;  // '9'

    // Parser phase
    typedef enum logic [1:0] {
        PH_WAIT = 2'd0,
        PH_NODE = 2'd1,
        PH_LEN  = 2'd2,
        PH_DATA = 2'd3
    } phase_t;

    // One result item
    typedef struct packed {
        logic               frame_done;
        logic               frame_error;
        logic               payload_valid;
        logic [7:0]         payload_byte;
        logic [INDEX_W-1:0] payload_index;
        logic [NODE_W-1:0]  node_id;
        logic [LEN_W-1:0]   payload_length;
    } result_t;

    // acc * 10 + digit, saturating at ACC_MAX
    function automatic logic [NODE_W-1:0] dec_push(input logic [NODE_W-1:0] acc,
                                                   input logic [7:0] c);
        logic [19:0] prod;
        logic [19:0] sum;
        prod = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0};
        sum  = prod + 20'(c - CH_ZERO);
        if (sum > 20'(ACC_MAX)) begin
            return ACC_MAX;
        end
        return sum[NODE_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/bfp_in_reg.sv
// Input register of the bencode frame parser: captures one received byte.
// Depends on nothing outside this file.
`default_nettype none

module bfp_in_reg (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,    // [7:0] rx_byte
    input  wire logic       take,       // parser consumes the held byte
    output logic            hold_valid,
    output logic [7:0]      hold_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    // Ready when empty or the held byte leaves this cycle
    assign s_tready   = !valid_reg || take;
    assign hold_valid = valid_reg;
    assign hold_byte  = byte_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_tready) begin
            valid_next = s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload register, no reset
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            byte_reg <= s_tdata;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/bfp_parse.sv
// Parser core: phase and accumulator registers plus the per-byte step logic.
// Depends on bfp_pkg.
`default_nettype none

module bfp_parse
    import bfp_pkg::*;
#(
    parameter int MAX_DATA = BFP_MAX_DATA
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       step_en,
    input  wire logic [7:0] rx_byte,
    output result_t         res
);

    localparam int CW = (MAX_DATA > 2) ? $clog2(MAX_DATA) : 1;

    phase_t              phase_reg;
    phase_t              phase_next;
    logic [NODE_W-1:0]   node_acc_reg;
    logic [NODE_W-1:0]   node_acc_next;
    logic [NODE_W-1:0]   length_acc_reg;
    logic [NODE_W-1:0]   length_acc_next;
    logic [CW-1:0]       byte_count_reg;
    logic [CW-1:0]       byte_count_next;
    logic [NODE_W-1:0]   count_ext;
    logic                is_digit;
    logic                done;
    logic                err;
    logic                pv;

    assign count_ext = NODE_W'(byte_count_reg);
    always_comb begin
        is_digit = rx_byte inside {[CH_ZERO:CH_NINE]};
    end

    // Next state
    always_comb begin
        phase_next      = phase_reg;
        node_acc_next   = node_acc_reg;
        length_acc_next = length_acc_reg;
        byte_count_next = byte_count_reg;
        done            = 1'b0;
        err             = 1'b0;
        pv              = 1'b0;
        case (phase_reg)
            PH_WAIT: begin
                if (rx_byte == CH_LIST) begin
                    phase_next = PH_NODE;
                end
            end
            PH_NODE: begin
                if (rx_byte == CH_INT) begin
                    node_acc_next = '0;
                end else if (is_digit) begin
                    node_acc_next = dec_push(node_acc_reg, rx_byte);
                end else if (rx_byte == CH_END) begin
                    length_acc_next = '0;
                    phase_next      = PH_LEN;
                end else begin
                    err = 1'b1;
                end
            end
            PH_LEN: begin
                if (rx_byte == CH_COLON) begin
                    if ({1'b0, length_acc_reg} >= 17'(MAX_DATA)) begin
                        err = 1'b1;
                    end else begin
                        phase_next      = PH_DATA;
                        byte_count_next = '0;
                    end
                end else if (is_digit) begin
                    length_acc_next = dec_push(length_acc_reg, rx_byte);
                end else begin
                    err = 1'b1;
                end
            end
            PH_DATA: begin
                if (count_ext < length_acc_reg) begin
                    pv              = 1'b1;
                    byte_count_next = byte_count_reg + CW'(1);
                end else begin
                    done = 1'b1;
                end
            end
            default: begin
                err = 1'b1;
            end
        endcase
        // Abandon, completion and stray bytes all return to waiting
        if (err || done || (phase_reg == PH_WAIT && rx_byte != CH_LIST)) begin
            phase_next      = PH_WAIT;
            node_acc_next   = '0;
            length_acc_next = '0;
            byte_count_next = '0;
        end
    end

    // Result of this byte
    always_comb begin
        res                = '0;
        res.frame_done     = done;
        res.frame_error    = err;
        res.payload_valid  = pv;
        if (pv) begin
            res.payload_byte  = rx_byte;
            res.payload_index = count_ext[INDEX_W-1:0];
        end
        if (done) begin
            res.node_id        = node_acc_reg;
            res.payload_length = length_acc_reg[LEN_W-1:0];
        end else begin
            res.node_id        = node_acc_next;
            res.payload_length = length_acc_next[LEN_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_WAIT;
            node_acc_reg   <= '0;
            length_acc_reg <= '0;
            byte_count_reg <= '0;
        end else if (step_en) begin
            phase_reg      <= phase_next;
            node_acc_reg   <= node_acc_next;
            length_acc_reg <= length_acc_next;
            byte_count_reg <= byte_count_next;
        end
    end

    // Completion never carries a payload byte or an error
    a_done_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && res.frame_done |-> !res.payload_valid && !res.frame_error)
        else $error("frame_done together with payload or error");

    // An abandoned frame reports cleared fields
    a_err_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && res.frame_error |-> res.node_id == '0 && res.payload_length == '0)
        else $error("abandon reports stale fields");

    // Waiting implies all accumulators are clear
    a_wait_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_WAIT |-> node_acc_reg == '0 && length_acc_reg == '0
                                 && byte_count_reg == '0)
        else $error("accumulators not clear while waiting");

    // Byte counter never passes the declared length
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_DATA |-> count_ext <= length_acc_reg)
        else $error("payload counter beyond length");

    // A payload byte keeps the parser in the payload phase
    a_data_stay: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && res.payload_valid |=> phase_reg == PH_DATA)
        else $error("left payload phase after payload byte");

endmodule

`default_nettype wire

// File: rtl/core/bfp_out_reg.sv
// Result register of the bencode frame parser: holds one result transfer.
// Depends on bfp_pkg.
`default_nettype none

module bfp_out_reg
    import bfp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        load,
    input  wire result_t     res_in,
    output logic             can_load,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // [7:0] payload_byte, [13:8] payload_index,
                                        // [29:14] node_id, [35:30] payload_length,
                                        // [39:36] zero
    output logic [1:0]       m_tuser,   // [0] frame_error, [1] payload_valid
    output logic             m_tlast    // frame_done
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    // Free when empty or the held result is taken this cycle
    assign can_load = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (can_load) begin
            valid_next = load;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && can_load) begin
            res_reg <= res_in;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {4'b0000, res_reg.payload_length, res_reg.node_id,
                       res_reg.payload_index, res_reg.payload_byte};
    assign m_tuser  = {res_reg.payload_valid, res_reg.frame_error};
    assign m_tlast  = res_reg.frame_done;

endmodule

`default_nettype wire

// File: rtl/core/bencode_frame_parser.sv
// Bencode frame parser, top level: input register, parser core, result register.
// Depends on bfp_pkg, bfp_in_reg, bfp_parse, bfp_out_reg.
//
//  channel | direction | content
//  s_*     | in        | tdata[7:0] rx_byte, one byte per transfer
//  m_*     | out       | tdata payload/index/node/length, tuser flags, tlast frame_done
//
// One result transfer per input transfer, one per cycle sustained while m_tready stays high.
// Each byte passes the input register, then the parse step into the result register.
// Reset (aresetn low, synchronous) returns the parser to waiting for 'l'.
// When m_tready is low the result register holds; the input register fills,
// then s_tready drops until the result is taken.
`default_nettype none

module bencode_frame_parser
    import bfp_pkg::*;
#(
    parameter int MAX_DATA = BFP_MAX_DATA
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // [7:0] payload_byte, [13:8] payload_index,
                                        // [29:14] node_id, [35:30] payload_length
    output logic [1:0]       m_tuser,   // [0] frame_error, [1] payload_valid
    output logic             m_tlast    // frame_done
);

    logic       hold_valid;
    logic [7:0] hold_byte;
    logic       can_load;
    logic       take;
    result_t    res;

    // A parse step happens when a byte is held and the result slot is free
    assign take = hold_valid && can_load;

    bfp_in_reg u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .take       (take),
        .hold_valid (hold_valid),
        .hold_byte  (hold_byte)
    );

    bfp_parse #(
        .MAX_DATA (MAX_DATA)
    ) u_parse (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (take),
        .rx_byte (hold_byte),
        .res     (res)
    );

    bfp_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (take),
        .res_in   (res),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

// File: dv/bencode_frame_parser_checker.sv
// Checker for the bencode frame parser: watches both stream channels, predicts
// one result per accepted byte and compares each result transfer in order.
// Depends on bfp_pkg.
`timescale 1ns / 1ps

module bencode_frame_parser_checker
    import bfp_pkg::*;
#(
    parameter int MAX_DATA = BFP_MAX_DATA
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [39:0] m_tdata,
    input  wire logic [1:0]  m_tuser,
    input  wire logic        m_tlast,
    output int               mismatches,
    output int               outstanding
);

    // Predicted parser state
    phase_t      frame_phase;
    logic [15:0] node_sum;
    logic [15:0] length_sum;
    logic [15:0] data_seen;

    // Results predicted but not yet seen on the result channel
    result_t     expected_results[$];

    initial mismatches = 0;
    initial outstanding = 0;

    task automatic clear_frame();
        frame_phase = PH_WAIT;
        node_sum    = '0;
        length_sum  = '0;
        data_seen   = '0;
    endtask

    // Decimal shift-in, clamped to the 16-bit ceiling
    function automatic logic [15:0] add_digit(input logic [15:0] sum, input logic [7:0] c);
        int unsigned v;
        v = int'(sum) * 10 + int'(c) - int'(CH_ZERO);
        return (v > int'(ACC_MAX)) ? ACC_MAX : v[15:0];
    endfunction

    // Advance the predicted parser by one byte and build its result
    task automatic parse_byte(input logic [7:0] c, output result_t r);
        logic digit;
        r = '0;
        digit = (c >= CH_ZERO) && (c <= CH_NINE);
        case (frame_phase)
            PH_WAIT: begin
                if (c == CH_LIST) frame_phase = PH_NODE;
                else clear_frame();
            end
            PH_NODE: begin
                if (c == CH_INT) begin
                    node_sum = '0;
                end else if (digit) begin
                    node_sum = add_digit(node_sum, c);
                end else if (c == CH_END) begin
                    length_sum  = '0;
                    frame_phase = PH_LEN;
                end else begin
                    clear_frame();
                    r.frame_error = 1'b1;
                end
            end
            PH_LEN: begin
                if (c == CH_COLON) begin
                    if (int'(length_sum) >= MAX_DATA) begin
                        clear_frame();
                        r.frame_error = 1'b1;
                    end else begin
                        frame_phase = PH_DATA;
                        data_seen   = '0;
                    end
                end else if (digit) begin
                    length_sum = add_digit(length_sum, c);
                end else begin
                    clear_frame();
                    r.frame_error = 1'b1;
                end
            end
            default: begin
                if (data_seen < length_sum) begin
                    r.payload_valid = 1'b1;
                    r.payload_byte  = c;
                    r.payload_index = data_seen[INDEX_W-1:0];
                    data_seen++;
                end else begin
                    r.frame_done = 1'b1;
                end
            end
        endcase
        r.node_id        = node_sum;
        r.payload_length = length_sum[LEN_W-1:0];
        if (r.frame_done) clear_frame();
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Predict on input transfers, compare on result transfers
    always @(posedge aclk) begin
        result_t r;
        if (!aresetn) begin
            clear_frame();
            expected_results.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                parse_byte(s_tdata, r);
                expected_results.push_back(r);
            end
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("result transfer with nothing expected");
                    mismatches++;
                end else begin
                    r = expected_results.pop_front();
                    check_field("frame_done", r.frame_done, m_tlast);
                    check_field("frame_error", r.frame_error, m_tuser[0]);
                    check_field("payload_valid", r.payload_valid, m_tuser[1]);
                    check_field("payload_byte", r.payload_byte, m_tdata[7:0]);
                    check_field("payload_index", r.payload_index, m_tdata[13:8]);
                    check_field("node_id", r.node_id, m_tdata[29:14]);
                    check_field("payload_length", r.payload_length, m_tdata[35:30]);
                end
            end
        end
        outstanding <= expected_results.size();
    end

endmodule

// File: dv/bencode_frame_parser_test.sv
// Testbench top for the bencode frame parser: clock, reset, byte stimulus,
// result-side back-pressure and the verdict.
// Depends on bfp_pkg, bencode_frame_parser and bencode_frame_parser_checker.
`timescale 1ns / 1ps

module bencode_frame_parser_test
    import bfp_pkg::*;
();

    localparam int TARGET_BYTES = 1400;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int LONG_HOLD    = 300;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    int mismatches;
    int outstanding;
    int bytes_sent  = 0;
    int cycle_count = 0;

    // Pacing controls shared by the sender and receiver processes
    bit calm      = 1'b0;   // no idling on either side
    bit burst     = 1'b0;   // sender offers back to back
    bit hold_req  = 1'b0;
    bit hold_on   = 1'b0;

    bencode_frame_parser i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    bencode_frame_parser_checker i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Run-away guard
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Idle length: mostly none, some short, a few long
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (calm) return 0;
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Result side: random stalls, one long hold-off on request
    initial begin
        int n;
        forever begin
            n = idle_cycles();
            if (hold_req && !hold_on) begin
                n = LONG_HOLD;
                hold_on = 1'b1;
            end
            if (n > 0) begin
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_tready <= 1'b1;
            if ($urandom_range(0, 9) == 0) repeat ($urandom_range(20, 60)) @(posedge aclk);
            else repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
    end

    // One byte transfer, then an optional sender gap
    task automatic send_byte(input logic [7:0] b);
        int gap;
        s_tdata  <= b;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
        gap = burst ? 0 : idle_cycles();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_str(input string txt);
        for (int i = 0; i < txt.len(); i++) send_byte(txt[i]);
    endtask

    function automatic string node_text();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return "";
        if (r == 1) return "65535";
        if (r == 2) return $sformatf("%0d", $urandom_range(65536, 9999999));
        return $sformatf("%0d", $urandom_range(0, 9999));
    endfunction

    // Mostly short payloads, a few at the top of the range, some over it
    function automatic int unsigned pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(0, 8);
        if (r < 88) return $urandom_range(9, 62);
        if (r < 94) return BFP_MAX_DATA - 1;
        if (r < 97) return $urandom_range(BFP_MAX_DATA, 999);
        return $urandom_range(65536, 999999);
    endfunction

    // Well-formed frame with random content; lengths past the limit get abandoned
    task automatic send_frame(input int unsigned len);
        string len_txt;
        send_byte(CH_LIST);
        if ($urandom_range(0, 9) != 0) send_byte(CH_INT);
        if ($urandom_range(0, 19) == 0) begin
            send_str(node_text());
            send_byte(CH_INT);
        end
        send_str(node_text());
        send_byte(CH_END);
        len_txt = $sformatf("%0d", len);
        if (len == 0 && $urandom_range(0, 1) == 0) len_txt = "";
        else if ($urandom_range(0, 7) == 0) len_txt = {"0", len_txt};
        send_str(len_txt);
        send_byte(CH_COLON);
        if (len < BFP_MAX_DATA) begin
            repeat (len) send_byte(8'($urandom_range(0, 255)));
            send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // Frame cut short by a byte the parser does not expect at that point
    task automatic send_broken();
        logic [7:0] bad;
        send_byte(CH_LIST);
        if ($urandom_range(0, 1)) send_byte(CH_INT);
        send_str(node_text());
        if ($urandom_range(0, 1)) begin
            send_byte(CH_END);
            send_str($sformatf("%0d", $urandom_range(0, 99)));
        end
        do bad = 8'($urandom_range(0, 255));
        while ((bad >= CH_ZERO && bad <= CH_NINE) || bad == CH_INT ||
               bad == CH_END || bad == CH_COLON);
        send_byte(bad);
    endtask

    // Stimulus and verdict
    initial begin
        int kind;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: stray bytes, empty frame, restart and saturation,
        // oversize length, bad bytes in the node and length parts
        send_byte(8'hFF);
        send_str("le:");
        send_byte(8'h00);
        send_str("li7i99999e2:");
        send_byte(8'hFF);
        send_byte(8'h80);
        send_str("e");
        send_str("le64:");
        send_str("lq");
        send_str("le?");

        // Random frames, noise and broken frames
        while (bytes_sent < TARGET_BYTES) begin
            calm = ($urandom_range(0, 9) == 0);
            kind = $urandom_range(0, 99);
            if (kind < 75) send_frame(pick_length());
            else if (kind < 88) send_broken();
            else repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));

            // Long receiver hold-off while the sender keeps pushing
            if (!hold_req && bytes_sent > TARGET_BYTES / 2) begin
                calm = 1'b0;
                hold_req = 1'b1;
                // Nothing on offer while waiting for the hold-off to start
                s_tvalid <= 1'b0;
                wait (hold_on);
                burst = 1'b1;
                send_frame(50);
                burst = 1'b0;
            end
        end
        calm = 1'b0;
        s_tvalid <= 1'b0;

        // Drain, then keep watching for anything spurious
        do @(posedge aclk); while (outstanding != 0);
        repeat (20) @(posedge aclk);

        if (mismatches == 0 && outstanding == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/bfp_pkg.sv
rtl/core/bfp_in_reg.sv
rtl/core/bfp_parse.sv
rtl/core/bfp_out_reg.sv
rtl/core/bencode_frame_parser.sv
dv/bencode_frame_parser_checker.sv
dv/bencode_frame_parser_test.sv
